// ----- sv/isr_pkg.sv -----
// shared types, widths and helpers for the integer square root block
// no dependencies; compiled first
package isr_pkg;

   // field and datapath widths
   localparam int RAD_W  = 64;          // radicand word
   localparam int ROOT_W = 32;          // integer root and fraction fields
   localparam int RES_W  = 64;          // full result: integer plus up to 32 fraction bits
   localparam int REM_W  = RES_W + 3;   // partial remainder with headroom for the trial subtract
   localparam int CFG_W  = 6;           // fraction bit request register
   localparam int FQ_W   = 4;           // fraction count in nibbles, 0..8
   localparam int CNT_W  = 6;           // step counter, up to 63
   localparam logic [FQ_W-1:0] MAX_FQ = 4'd8;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // controls from the sequencer to the datapath and output stage
   typedef struct packed {
      logic load;   // capture a new radicand, clear remainder and result
      logic step;   // run one digit pair through the shared subtractor
      logic emit;   // move the finished result into the output register
   } isr_ctrl_type;

   // round the request up to whole nibbles and cap at 32 bits
   function automatic logic [FQ_W-1:0] eff_fq(input logic [CFG_W-1:0] frac);
      logic [CFG_W:0] sum;
      logic [CFG_W-2:0] q;
      sum = {1'b0, frac} + (CFG_W+1)'(3);
      q   = sum[CFG_W:2];
      if (q > {1'b0, MAX_FQ})
         return MAX_FQ;
      else
         return q[FQ_W-1:0];
   endfunction

endpackage

// ----- sv/isr_req_if.sv -----
// request channel: valid/ready handshake carrying one radicand word
// depends on isr_pkg for the word width
interface isr_req_if;
   import isr_pkg::*;

   logic             valid;
   logic             ready;
   logic [RAD_W-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

// ----- sv/isr_rsp_if.sv -----
// response channel: valid/ready handshake carrying root and fraction
// depends on isr_pkg for the field widths
interface isr_rsp_if;
   import isr_pkg::*;

   logic              valid;
   logic              ready;
   logic [ROOT_W-1:0] root;
   logic [ROOT_W-1:0] root_fraction;

   modport source (output valid, output root, output root_fraction, input ready);
   modport sink   (input valid, input root, input root_fraction, output ready);
endinterface

// ----- sv/isr_datapath.sv -----
// restoring square root datapath: radicand shifter, remainder and result registers
// one shared trial subtractor used once per step; depends on isr_pkg
module isr_datapath #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                       clock,
   input  isr_pkg::isr_ctrl_type      ctrl,
   input  logic [isr_pkg::RAD_W-1:0]  radicand,
   output logic [isr_pkg::RES_W-1:0]  result
);
   import isr_pkg::*;

   localparam logic [RAD_W-1:0] VAL_MASK = {RAD_W{1'b1}} >> (RAD_W - VALUE_WIDTH);

   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RES_W-1:0] res_ff, res_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic [REM_W:0]   diff;
   logic             fits;

   // bring in the next bit pair and try subtracting 4*res+1
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {{(REM_W-RES_W-2){1'b0}}, res_ff, 2'b01};
      diff   = {1'b0, rem_sh} - {1'b0, trial};
      fits   = ~diff[REM_W];
   end

   // next register values
   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      if (ctrl.load) begin
         rad_in = radicand & VAL_MASK;
         rem_in = '0;
         res_in = '0;
      end else if (ctrl.step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in = fits ? diff[REM_W-1:0] : rem_sh;
         res_in = {res_ff[RES_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// ----- sv/isr_ctrl.sv -----
// sequencer: accepts a word, counts 32+F digit steps, then hands off the result
// depends on isr_pkg for the state type and control struct
module isr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [isr_pkg::FQ_W-1:0]    fq,
   input  logic                        out_free,
   output logic                        req_ready,
   output isr_pkg::isr_ctrl_type       ctrl
);
   import isr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_step;

   assign last_step = (cnt_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_step)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_RUN: begin
            ctrl.step = 1'b1;
         end
         ST_DONE: begin
            ctrl.emit = out_free;
         end
         default: ;
      endcase
   end

   // step counter: 31+4*fq down to zero
   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.load)
         cnt_in = CNT_W'(ROOT_W - 1) + CNT_W'({fq, 2'b00});
      else if (ctrl.step && !last_step)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // a new word always starts at least 32 steps
   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (state_ff == ST_RUN) && (cnt_ff >= CNT_W'(ROOT_W - 1)))
      else $error("load did not start a full step run");

   // the final step leads straight to the hand-off state
   a_last_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && last_step |=> (state_ff == ST_DONE))
      else $error("run did not end after the last step");

   // steps keep running while the count is not exhausted
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !last_step |=> (state_ff == ST_RUN) && !ctrl.emit)
      else $error("run left early");

endmodule

// ----- sv/int_sqrt_with_fraction.sv -----
// integer square root with fraction: floor(sqrt(radicand * 4^F)), F = frac_bits up to nibble
// a word is accepted in idle, runs 32 + F digit steps, then is handed off; F in 0..32
// the single shared trial subtractor takes no new word until the current one is handed off
// the next word is accepted while a finished result waits in the output register
// reset (synchronous, active high) clears the sequencer, output valid and frac_bits to 0
module int_sqrt_with_fraction #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   isr_req_if.sink                     req,
   isr_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic [isr_pkg::CFG_W-1:0]   csr_wdata
);
   import isr_pkg::*;

   logic [CFG_W-1:0]  frac_bits_ff, frac_bits_in;
   logic [FQ_W-1:0]   fq_ff, fq_in;
   logic [FQ_W-1:0]   fq_req;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] frac_ff, frac_in;

   isr_ctrl_type      ctrl;
   logic [RES_W-1:0]  result;
   logic              out_free;
   logic [CNT_W-1:0]  sh_amt;
   logic [RES_W-1:0]  res_sh;
   logic [RES_W-1:0]  frac_mask;
   logic [RES_W-1:0]  frac_full;

   assign fq_req   = eff_fq(frac_bits_ff);
   assign out_free = ~rsp_valid_ff | rsp.ready;

   isr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .fq        (fq_req),
      .out_free  (out_free),
      .req_ready (req.ready),
      .ctrl      (ctrl)
   );

   isr_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .ctrl     (ctrl),
      .radicand (req.radicand),
      .result   (result)
   );

   // fraction register and per-word nibble count
   always_comb begin
      frac_bits_in = csr_we ? csr_wdata : frac_bits_ff;
      fq_in        = ctrl.load ? fq_req : fq_ff;
   end

   function automatic logic [ROOT_W-1:0] emit_sel(input logic sel,
                                                  input logic [ROOT_W-1:0] a,
                                                  input logic [ROOT_W-1:0] b);
      return sel ? a : b;
   endfunction

   // split the result at bit F
   always_comb begin
      sh_amt    = {fq_ff, 2'b00};
      res_sh    = result >> sh_amt;
      frac_mask = ~({RES_W{1'b1}} << sh_amt);
      frac_full = result & frac_mask;
      root_in   = emit_sel(ctrl.emit, res_sh[ROOT_W-1:0], root_ff);
      frac_in   = emit_sel(ctrl.emit, frac_full[ROOT_W-1:0], frac_ff);
   end

   // output word valid
   always_comb begin
      rsp_valid_in = ctrl.emit | (rsp_valid_ff & ~rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_bits_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frac_bits_ff <= frac_bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fq_ff   <= fq_in;
      root_ff <= root_in;
      frac_ff <= frac_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.root          = root_ff;
   assign rsp.root_fraction = frac_ff;

   // a result is only moved in when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> out_free)
      else $error("result emitted over a waiting word");

   // an emitted word shows up as valid in the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |=> rsp_valid_ff)
      else $error("emitted word not presented");

   // without a fraction count the fraction field is zero when a word is emitted
   a_zero_frac: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit && (fq_ff == '0) |=> (frac_ff == '0))
      else $error("fraction bits present with zero fraction count");

endmodule
